// File: rtl/core/xtea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA cipher package
// Word types and cipher constants shared by the pipeline stages and the top
// level, and the round helper functions used by the pipeline stages.
// ----------------------------------------------------------------------------
package xtea_pkg;

	localparam int ROUND_COUNT_DEFAULT = 32;
	localparam int KEY_WORDS = 4;
	localparam int KEY_IDX_W = 2;
	localparam int ADDR_W = 4;

	localparam logic [31:0] CIPHER_DELTA = 32'h9E3779B9;
	localparam logic [31:0] DECRYPT_SUM_DEFAULT = 32'hC6EF3720;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	typedef struct packed {
		logic [31:0] block_low;
		logic [31:0] block_high;
		logic        opcode;
	} cmd_t;

	typedef struct packed {
		logic [31:0] result_low;
		logic [31:0] result_high;
	} result_t;

	typedef struct packed {
		logic        opcode;
		logic [31:0] y;
		logic [31:0] z;
	} stage_t;

	typedef logic [KEY_WORDS-1:0][31:0] key_t;

	function automatic logic [31:0] mix_word(input logic [31:0] w);
		return ((w << 4) ^ (w >> 5)) + w;
	endfunction

	function automatic logic [31:0] sum_at(input int n);
		logic [31:0] nn;
		nn = 32'(n);
		return nn * CIPHER_DELTA;
	endfunction

endpackage

// File: rtl/core/xtea_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block cipher
// Fully pipelined 64-bit block cipher with a 128-bit key, one round a stage.
// ----------------------------------------------------------------------------
// Usage:
// The key is written as four 32-bit words over the APB port at byte
// addresses 0, 4, 8 and 12, and reads back at the same addresses. The user
// must change keys only while no word is in flight; the block does not enforce it.
// A command word (block halves and opcode, 0 encrypt, 1 decrypt) is taken
// at every clock edge where start is high; busy is always low, so a new
// word may enter every cycle.
// Each cipher cycle occupies one pipeline stage, and the result leaves the
// last stage register on the result port for one cycle
// with done high. Throughput is one word per cycle.
// Reset clears the stage valid bits and the key words to zero. Words in
// flight at reset are dropped. The receiver cannot stall: results are
// presented once and must be taken.
// ----------------------------------------------------------------------------
module xtea_block_cipher #(
	parameter int ROUND_COUNT = xtea_pkg::ROUND_COUNT_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  xtea_pkg::cmd_t              blk,
	output logic                        done,
	output xtea_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [xtea_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	xtea_pkg::key_t key_q;
	logic [xtea_pkg::KEY_IDX_W-1:0] key_idx;
	logic [ROUND_COUNT:0] valid_pipe;
	xtea_pkg::stage_t word_pipe [ROUND_COUNT+1];

	assign key_idx = paddr[xtea_pkg::ADDR_W-1:2];
	assign pready = 1'b1;
	assign prdata = key_q[key_idx];
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (psel && penable && pwrite) begin
			key_q[key_idx] <= pwdata;
		end
	end

	assign valid_pipe[0] = start;
	assign word_pipe[0].opcode = blk.opcode;
	assign word_pipe[0].y = blk.block_low;
	assign word_pipe[0].z = blk.block_high;

	for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
		xtea_round #(
			.ROUND_COUNT(ROUND_COUNT),
			.STAGE(g)
		) u_round (
			.clk(clk),
			.arst_n(arst_n),
			.valid_in(valid_pipe[g]),
			.word_in(word_pipe[g]),
			.key(key_q),
			.valid_s1(valid_pipe[g+1]),
			.word_s1(word_pipe[g+1])
		);
	end

	assign done = valid_pipe[ROUND_COUNT];
	assign result.result_low = word_pipe[ROUND_COUNT].y;
	assign result.result_high = word_pipe[ROUND_COUNT].z;

endmodule

// File: rtl/core/xtea_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA pipeline round
// One registered cycle of the cipher: two Feistel half-rounds, with the sum
// and key selection fixed by the stage position for each direction.
// ----------------------------------------------------------------------------
module xtea_round #(
	parameter int ROUND_COUNT = xtea_pkg::ROUND_COUNT_DEFAULT,
	parameter int STAGE = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_in,
	input  xtea_pkg::stage_t word_in,
	input  xtea_pkg::key_t   key,
	output logic             valid_s1,
	output xtea_pkg::stage_t word_s1
);

	localparam logic [31:0] ENC_S0 = xtea_pkg::sum_at(STAGE);
	localparam logic [31:0] ENC_S1 = xtea_pkg::sum_at(STAGE + 1);
	localparam logic [31:0] DEC_S0 = xtea_pkg::sum_at(ROUND_COUNT - STAGE);
	localparam logic [31:0] DEC_S1 = xtea_pkg::sum_at(ROUND_COUNT - STAGE - 1);

	localparam logic [xtea_pkg::KEY_IDX_W-1:0] ENC_K0 = ENC_S0[1:0];
	localparam logic [xtea_pkg::KEY_IDX_W-1:0] ENC_K1 = ENC_S1[12:11];
	localparam logic [xtea_pkg::KEY_IDX_W-1:0] DEC_K0 = DEC_S0[12:11];
	localparam logic [xtea_pkg::KEY_IDX_W-1:0] DEC_K1 = DEC_S1[1:0];

	logic [31:0] enc_y;
	logic [31:0] enc_z;
	logic [31:0] dec_y;
	logic [31:0] dec_z;
	xtea_pkg::stage_t word_next;

	always_comb begin
		enc_y = word_in.y + (xtea_pkg::mix_word(word_in.z) ^ (ENC_S0 + key[ENC_K0]));
		enc_z = word_in.z + (xtea_pkg::mix_word(enc_y) ^ (ENC_S1 + key[ENC_K1]));
		dec_z = word_in.z - (xtea_pkg::mix_word(word_in.y) ^ (DEC_S0 + key[DEC_K0]));
		dec_y = word_in.y - (xtea_pkg::mix_word(dec_z) ^ (DEC_S1 + key[DEC_K1]));
		word_next.opcode = word_in.opcode;
		if (word_in.opcode == xtea_pkg::OP_DECRYPT) begin
			word_next.y = dec_y;
			word_next.z = dec_z;
		end else begin
			word_next.y = enc_y;
			word_next.z = enc_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in) begin
			word_s1 <= word_next;
		end
	end

endmodule

// File: rtl/core/xtea_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA cipher port checker
// Checks latency, flow and key readback as seen on the top-level ports.
// ----------------------------------------------------------------------------
module xtea_checker #(
	parameter int ROUND_COUNT = xtea_pkg::ROUND_COUNT_DEFAULT
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [xtea_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                 pwdata,
	input logic [31:0]                 prdata
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised on a fully pipelined cipher");

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##ROUND_COUNT done)
		else $error("accepted word did not complete after the pipeline latency");

	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, ROUND_COUNT))
		else $error("result strobe without a matching command word");

	a_key_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite) ##1 (psel && !pwrite && paddr == $past(paddr))
		|-> prdata == $past(pwdata))
		else $error("key word readback does not match the last write");

endmodule

bind xtea_block_cipher xtea_checker #(
	.ROUND_COUNT(ROUND_COUNT)
) u_xtea_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata)
);

// File: dv/xtea_block_cipher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block cipher testbench
// Drives command words into the cipher under several keys written over the
// APB port, and checks every result word and every key read-back against a
// local model of the cipher. Keys start at their all-zero reset value, move
// to all ones, then a fixed byte-pattern key and then random settings, with
// encrypt and decrypt round trips mixed into random traffic.
// ----------------------------------------------------------------------------
module xtea_block_cipher_tb;
	import xtea_pkg::*;

	localparam int ROUNDS = ROUND_COUNT_DEFAULT;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_WORDS = 110;

	class block_scoreboard;
		key_t key_words;
		result_t expected_blocks[$];
		int failures;

		function new();
			key_words = '0;
			failures = 0;
		endfunction

		function logic [31:0] round_mix(logic [31:0] w);
			return ((w << 4) ^ (w >> 5)) + w;
		endfunction

		function result_t cipher_block(cmd_t c);
			logic [31:0] y;
			logic [31:0] z;
			logic [31:0] sum;
			result_t r;
			y = c.block_low;
			z = c.block_high;
			if (op_t'(c.opcode) == OP_ENCRYPT) begin
				sum = '0;
				for (int i = 0; i < ROUNDS; i++) begin
					y = y + (round_mix(z) ^ (sum + key_words[sum[1:0]]));
					sum = sum + CIPHER_DELTA;
					z = z + (round_mix(y) ^ (sum + key_words[sum[12:11]]));
				end
			end else begin
				sum = CIPHER_DELTA * 32'(ROUNDS);
				for (int i = 0; i < ROUNDS; i++) begin
					z = z - (round_mix(y) ^ (sum + key_words[sum[12:11]]));
					sum = sum - CIPHER_DELTA;
					y = y - (round_mix(z) ^ (sum + key_words[sum[1:0]]));
				end
			end
			r.result_low = y;
			r.result_high = z;
			return r;
		endfunction

		function void note_command(cmd_t c);
			expected_blocks.push_back(cipher_block(c));
		endfunction

		function void check_result(result_t r);
			result_t want;
			if (expected_blocks.size() == 0) begin
				$error("result word with no command outstanding: %h", r);
				failures++;
			end else begin
				want = expected_blocks.pop_front();
				if (r.result_low !== want.result_low) begin
					$error("result_low mismatch: expected %h, actual %h",
						want.result_low, r.result_low);
					failures++;
				end
				if (r.result_high !== want.result_high) begin
					$error("result_high mismatch: expected %h, actual %h",
						want.result_high, r.result_high);
					failures++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t blk;
	logic done;
	result_t result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	block_scoreboard sb;
	int cycle_count = 0;

	xtea_block_cipher #(
		.ROUND_COUNT(ROUNDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.blk(blk),
		.done(done),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_command(blk);
			if (done)
				sb.check_result(result);
		end
	end

	function automatic logic [31:0] pick_word();
		logic [31:0] edges [5];
		edges = '{32'h0, 32'hFFFFFFFF, 32'h1, 32'h80000000, 32'h7FFFFFFF};
		if ($urandom_range(7) == 0)
			return edges[$urandom_range(4)];
		return $urandom;
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		c.block_low = pick_word();
		c.block_high = pick_word();
		c.opcode = 1'($urandom_range(1));
		return c;
	endfunction

	task automatic send_block(cmd_t c, bit may_pause);
		start <= 1'b1;
		blk <= c;
		do @(posedge clk); while (busy);
		if (may_pause && $urandom_range(99) < 3) begin
			start <= 1'b0;
			blk <= random_cmd();
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_fields(logic [31:0] lo, logic [31:0] hi, op_t op);
		cmd_t c;
		c.block_low = lo;
		c.block_high = hi;
		c.opcode = op;
		send_block(c, 1'b0);
	endtask

	// The second word feeds the first word's expected output back through
	// the opposite mode, so it should come out as the original block.
	task automatic send_round_trip(cmd_t c, bit may_pause);
		result_t r;
		cmd_t back;
		send_block(c, may_pause);
		r = sb.cipher_block(c);
		back.block_low = r.result_low;
		back.block_high = r.result_high;
		back.opcode = ~c.opcode;
		send_block(back, may_pause);
	endtask

	task automatic stop_and_drain();
		start <= 1'b0;
		blk <= random_cmd();
		while (sb.expected_blocks.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(int idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.key_words[idx] = value;
	endtask

	task automatic apb_read_check(int idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_W'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== sb.key_words[idx]) begin
			$error("prdata mismatch: expected %h, actual %h", sb.key_words[idx], prdata);
			sb.failures++;
		end
	endtask

	task automatic load_keys(key_t k);
		for (int i = 0; i < KEY_WORDS; i++)
			apb_write(i, k[i]);
		for (int i = 0; i < KEY_WORDS; i++)
			apb_read_check(i);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		cmd_t c;
		key_t k;
		int n;
		bit steady;
		sb = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		blk <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < KEY_WORDS; i++)
			apb_read_check(i);
		psel <= 1'b0;
		penable <= 1'b0;

		send_fields(32'h0, 32'h0, OP_ENCRYPT);
		send_fields(32'h0, 32'h0, OP_DECRYPT);
		send_fields(32'hFFFFFFFF, 32'hFFFFFFFF, OP_ENCRYPT);
		send_fields(32'hFFFFFFFF, 32'hFFFFFFFF, OP_DECRYPT);
		c = '{block_low: 32'h0, block_high: 32'hFFFFFFFF, opcode: OP_ENCRYPT};
		send_round_trip(c, 1'b0);
		stop_and_drain();

		load_keys({4{32'hFFFFFFFF}});
		send_fields(32'h0, 32'h0, OP_ENCRYPT);
		send_fields(32'h0, 32'h0, OP_DECRYPT);
		send_fields(32'hFFFFFFFF, 32'hFFFFFFFF, OP_ENCRYPT);
		send_fields(32'hFFFFFFFF, 32'hFFFFFFFF, OP_DECRYPT);
		c = '{block_low: 32'hFFFFFFFF, block_high: 32'h0, opcode: OP_DECRYPT};
		send_round_trip(c, 1'b0);
		stop_and_drain();

		load_keys({32'h0C0D0E0F, 32'h08090A0B, 32'h04050607, 32'h00010203});
		send_fields(32'h41424344, 32'h45464748, OP_ENCRYPT);
		c = '{block_low: 32'h80000000, block_high: 32'h00000001, opcode: OP_ENCRYPT};
		send_round_trip(c, 1'b0);
		send_fields(32'h7FFFFFFF, 32'h80000000, OP_DECRYPT);
		send_fields(32'h1, 32'h0, OP_DECRYPT);
		stop_and_drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			for (int i = 0; i < KEY_WORDS; i++)
				k[i] = pick_word();
			load_keys(k);
			steady = (p == 2);
			n = 0;
			while (n < PHASE_WORDS) begin
				if ($urandom_range(99) < 30) begin
					send_round_trip(random_cmd(), !steady);
					n += 2;
				end else begin
					send_block(random_cmd(), !steady);
					n++;
				end
			end
			stop_and_drain();
		end

		repeat (ROUNDS + 8) @(posedge clk);
		if (sb.failures == 0 && sb.expected_blocks.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
